// ===== rtl/core/gff_pkg.sv =====
// Shared constants and types for the grid region-size block.
package gff_pkg;

	localparam int COORD_W = 4;
	localparam int VALUE_W = 8;
	localparam int COUNT_W = 8;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Operation strobes broadcast from the sequencer to every grid cell.
	typedef struct packed {
		logic load;
		logic grow;
		logic shift;
	} cell_ctrl_t;

endpackage

// ===== rtl/core/gff_if.sv =====
// Handshake channels for request items and result items.
interface gff_req_if;
	import gff_pkg::*;

	logic               valid;
	logic               ready;
	logic               req_type;
	logic [COORD_W-1:0] col;
	logic [COORD_W-1:0] row;
	logic [VALUE_W-1:0] cell_value;

	modport source (output valid, req_type, col, row, cell_value, input ready);
	modport sink (input valid, req_type, col, row, cell_value, output ready);
endinterface

interface gff_res_if;
	import gff_pkg::*;

	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] chain_count;

	modport source (output valid, chain_count, input ready);
	modport sink (input valid, chain_count, output ready);
endinterface

// ===== rtl/core/gff_cell.sv =====
// One grid cell: stored value plus its reached flag.
module gff_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gff_pkg::cell_ctrl_t         ctrl,
	input  logic                        seed,
	input  logic                        wr_en,
	input  logic [gff_pkg::VALUE_W-1:0] wr_value,
	input  logic [gff_pkg::VALUE_W-1:0] target,
	input  logic [3:0]                  nbr_reached,
	input  logic                        prev_reached,
	output logic                        reached,
	output logic [gff_pkg::VALUE_W-1:0] value
);
	import gff_pkg::*;

	logic [VALUE_W-1:0] value_q;
	logic               reached_q;
	logic               match;

	assign match = (value_q == target);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			value_q <= wr_value;
		end
	end

	// During the fill the flag spreads from any reached neighbor holding the
	// same value; during the count the flags shift along the cell chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reached_q <= 1'b0;
		end else if (ctrl.load) begin
			reached_q <= seed;
		end else if (ctrl.grow) begin
			reached_q <= reached_q | (match & (|nbr_reached));
		end else if (ctrl.shift) begin
			reached_q <= prev_reached;
		end
	end

	assign reached = reached_q;
	assign value   = value_q;
endmodule

// ===== rtl/core/grid_flood_fill_region_size.sv =====
// Region-size engine: a grid of cells with a fill and count sequencer.
//
// Usage: items arrive on req. A write item (req_type 0) stores cell_value
// at (row, col) and gives no result; writes outside the grid are dropped.
// A query item (req_type 1) gives one result on res: the number of cells
// 4-connected to the start cell through cells of equal value, start
// excluded, saturating at 255. A start outside the grid skips the fill
// and the count and answers 0.
// A query runs in steps: it loads the start, then fills, with reached
// flags spreading one cell per cycle for long enough to cover the longest
// path in the grid, then shifts the flags out of the cell chain into a
// counter, then passes the count to the output register. One query is
// worked on at a time; req.ready is low for its whole run, so no item is
// taken until its result is in the output register, while writes go at
// one per cycle when no query runs.
// Reset clears all reached flags, the sequencer and the result valid flag;
// grid values are undefined until written.
// A stalled receiver holds the result in the output register; new items are
// still taken, and a second query finishes its count and then waits for the
// output register to free.
module grid_flood_fill_region_size #(
	parameter int GRID_WIDTH  = 16,
	parameter int GRID_HEIGHT = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	gff_req_if.sink   req,
	gff_res_if.source res
);
	import gff_pkg::*;

	localparam int CELLS  = GRID_WIDTH * GRID_HEIGHT;
	localparam int IDX_W  = $clog2(CELLS);
	localparam int STEP_W = $clog2(CELLS);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOAD  = 3'd1;
	localparam logic [2:0] S_FILL  = 3'd2;
	localparam logic [2:0] S_COUNT = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CELLS - 1);
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	logic [2:0]         state_q;
	logic [STEP_W-1:0]  step_q;
	logic [COORD_W-1:0] start_row_q;
	logic [COORD_W-1:0] start_col_q;
	logic [VALUE_W-1:0] target_q;
	logic [COUNT_W-1:0] tally_q;
	logic               skip_q;
	logic               res_valid_q;
	logic [COUNT_W-1:0] res_count_q;

	logic               in_fire;
	logic               req_inside;
	logic [IDX_W-1:0]   start_idx;
	logic               emit_go;
	cell_ctrl_t         ctrl;

	logic [CELLS-1:0]   reached;
	logic [VALUE_W-1:0] values [CELLS];

	assign req.ready   = (state_q == S_IDLE);
	assign in_fire     = req.valid && req.ready;
	assign req_inside  = (32'(req.col) < GRID_WIDTH) && (32'(req.row) < GRID_HEIGHT);
	assign start_idx   = IDX_W'(32'(start_row_q) * GRID_WIDTH + 32'(start_col_q));
	assign emit_go     = (state_q == S_EMIT) && (!res_valid_q || res.ready);

	assign ctrl.load  = (state_q == S_LOAD);
	assign ctrl.grow  = (state_q == S_FILL);
	assign ctrl.shift = (state_q == S_COUNT);

	for (genvar r = 0; r < GRID_HEIGHT; r++) begin : g_row
		for (genvar c = 0; c < GRID_WIDTH; c++) begin : g_col
			localparam int IDX = r * GRID_WIDTH + c;
			logic [3:0] nbr;
			logic       prev;
			logic       wr_en;
			logic       seed;

			assign nbr[0] = (r > 0) ? reached[(r > 0) ? IDX - GRID_WIDTH : IDX] : 1'b0;
			assign nbr[1] = (r + 1 < GRID_HEIGHT) ?
				reached[(r + 1 < GRID_HEIGHT) ? IDX + GRID_WIDTH : IDX] : 1'b0;
			assign nbr[2] = (c > 0) ? reached[(c > 0) ? IDX - 1 : IDX] : 1'b0;
			assign nbr[3] = (c + 1 < GRID_WIDTH) ?
				reached[(c + 1 < GRID_WIDTH) ? IDX + 1 : IDX] : 1'b0;
			assign prev   = (IDX > 0) ? reached[(IDX > 0) ? IDX - 1 : IDX] : 1'b0;

			assign wr_en = in_fire && (req.req_type == REQ_WRITE) &&
				(32'(req.row) == r) && (32'(req.col) == c);
			assign seed  = (32'(start_row_q) == r) && (32'(start_col_q) == c);

			gff_cell u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.ctrl         (ctrl),
				.seed         (seed),
				.wr_en        (wr_en),
				.wr_value     (req.cell_value),
				.target       (target_q),
				.nbr_reached  (nbr),
				.prev_reached (prev),
				.reached      (reached[IDX]),
				.value        (values[IDX])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			start_row_q <= req.row;
			start_col_q <= req.col;
		end
		if (state_q == S_LOAD) begin
			target_q <= values[start_idx];
		end
		if (emit_go) begin
			res_count_q <= tally_q;
		end
	end

	// A new result may be loaded in the same cycle the held one is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_go) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			tally_q     <= '0;
			skip_q      <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire && (req.req_type == REQ_QUERY)) begin
						if (req_inside) begin
							state_q <= S_LOAD;
						end else begin
							tally_q <= '0;
							state_q <= S_EMIT;
						end
					end
				end
				S_LOAD: begin
					step_q  <= STEP_LAST;
					state_q <= S_FILL;
				end
				S_FILL: begin
					if (step_q == '0) begin
						step_q  <= STEP_LAST;
						tally_q <= '0;
						skip_q  <= 1'b1;
						state_q <= S_COUNT;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				S_COUNT: begin
					// The first reached flag out of the chain is not counted; this leaves
					// the start cell, which is always reached, out of the count.
					if (reached[CELLS-1]) begin
						if (skip_q) begin
							skip_q <= 1'b0;
						end else if (tally_q != COUNT_MAX) begin
							tally_q <= tally_q + 1'b1;
						end
					end
					if (step_q == '0) begin
						state_q <= S_EMIT;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res.valid       = res_valid_q;
	assign res.chain_count = res_count_q;
endmodule

// ===== rtl/core/gff_checker.sv =====
// Port-level checks for the region-size engine, bound to the top level.
module gff_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        req_type,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic [gff_pkg::COUNT_W-1:0] chain_count
);
	import gff_pkg::*;

	// A held result keeps its value until it is taken.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(chain_count))
		else $error("result item changed while stalled");

	// A query occupies the engine, so no item is taken right after it.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_type == REQ_QUERY) |=> !req_ready)
		else $error("item taken right after a query");

	// A write item leaves the engine ready for the next item.
	a_write_quick: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_type == REQ_WRITE) |=> req_ready)
		else $error("engine busy after a write item");

	// A result never appears in the cycle right after a query is taken.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_type == REQ_QUERY) && !res_valid |=> !res_valid)
		else $error("result appeared too early");
endmodule

bind grid_flood_fill_region_size gff_checker u_gff_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.req_type    (req.req_type),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.chain_count (res.chain_count)
);

// ===== test/tb.sv =====
// Testbench for the grid region-size block: directed and random writes and queries.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gff_pkg::*;

	localparam int GRID_W = 16;
	localparam int GRID_H = 16;
	localparam int CELLS  = GRID_W * GRID_H;
	localparam int FILL_CYCLES = 2 * CELLS + 8;

	logic clk;
	logic arst_n;

	gff_req_if req_ch ();
	gff_res_if res_ch ();

	grid_flood_fill_region_size #(
		.GRID_WIDTH (GRID_W),
		.GRID_HEIGHT(GRID_H)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.res   (res_ch)
	);

	logic [VALUE_W-1:0] grid_model [CELLS];
	logic [COUNT_W-1:0] counts_due [$];

	int src_idle_pct;
	int sink_idle_pct;
	int hold_left;
	int mismatches;
	int items_sent;
	int writes_sent;
	int queries_sent;
	int counts_checked;
	int largest_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Region size minus one: every cell 4-connected to the start through equal values.
	function automatic logic [COUNT_W-1:0] region_size_minus_one(int c, int r);
		bit seen [CELLS];
		int stack [$];
		int reached;
		int idx;
		int x;
		int y;
		int nx;
		int ny;
		int n;
		int k;
		logic [VALUE_W-1:0] target;
		if (c >= GRID_W || r >= GRID_H) begin
			return '0;
		end
		reached = 0;
		idx = r * GRID_W + c;
		target = grid_model[idx];
		seen[idx] = 1'b1;
		stack.push_back(idx);
		while (stack.size() > 0) begin
			idx = stack.pop_back();
			x = idx % GRID_W;
			y = idx / GRID_W;
			for (k = 0; k < 4; k++) begin
				nx = x + ((k == 2) ? -1 : (k == 3) ? 1 : 0);
				ny = y + ((k == 0) ? -1 : (k == 1) ? 1 : 0);
				if (nx >= 0 && nx < GRID_W && ny >= 0 && ny < GRID_H) begin
					n = ny * GRID_W + nx;
					if (!seen[n] && grid_model[n] == target) begin
						seen[n] = 1'b1;
						stack.push_back(n);
						reached++;
					end
				end
			end
		end
		return (reached > 255) ? 8'd255 : reached[COUNT_W-1:0];
	endfunction

	task automatic report_mismatch(string what, int expected, int actual);
		$display("MISMATCH %s: expected %0d, got %0d at %0t", what, expected, actual, $realtime);
		mismatches++;
	endtask

	// Offers an item, awaits its handshake, updates the grid copy or the count queue.
	task automatic send_item(logic kind, logic [COORD_W-1:0] c, logic [COORD_W-1:0] r,
			logic [VALUE_W-1:0] value);
		if ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= kind;
		req_ch.col        <= c;
		req_ch.row        <= r;
		req_ch.cell_value <= value;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		items_sent++;
		if (kind == REQ_WRITE) begin
			writes_sent++;
			if (c < GRID_W && r < GRID_H) begin
				grid_model[r * GRID_W + c] = value;
			end
		end else begin
			queries_sent++;
			counts_due.push_back(region_size_minus_one(c, r));
		end
	endtask

	task automatic put_cell(int c, int r, int value);
		send_item(REQ_WRITE, c[COORD_W-1:0], r[COORD_W-1:0], value[VALUE_W-1:0]);
	endtask

	task automatic ask_region(int c, int r);
		send_item(REQ_QUERY, c[COORD_W-1:0], r[COORD_W-1:0], VALUE_W'($urandom_range(255)));
	endtask

	function automatic int pick_value();
		int palette [4] = '{8'h00, 8'h5A, 8'hA5, 8'hFF};
		if ($urandom_range(3) == 0) begin
			return $urandom_range(255);
		end
		return palette[$urandom_range(3)];
	endfunction

	// Every cell is written before the first query, since the fill compares them all.
	task automatic test_grid_setup();
		int c;
		int r;
		for (r = 0; r < GRID_H; r++) begin
			for (c = 0; c < GRID_W; c++) begin
				put_cell(c, r, 0);
			end
		end
	endtask

	task automatic test_directed_regions();
		ask_region(0, 0);
		ask_region(GRID_W - 1, GRID_H - 1);
		put_cell(7, 8, 255);
		ask_region(7, 8);
		ask_region(8, 7);
		// Corner cut off from the rest by two cells of another value.
		put_cell(1, 0, 8'hA5);
		put_cell(0, 1, 8'hA5);
		ask_region(0, 0);
		ask_region(1, 0);
		put_cell(0, 0, 8'hA5);
		ask_region(0, 1);
		put_cell(GRID_W - 1, 0, 8'h5A);
		ask_region(GRID_W - 1, 0);
		put_cell(GRID_W - 2, 0, 8'h5A);
		ask_region(GRID_W - 2, 0);
		put_cell(GRID_W - 1, GRID_H - 2, 255);
		put_cell(GRID_W - 2, GRID_H - 1, 255);
		ask_region(GRID_W - 1, GRID_H - 1);
		ask_region(GRID_W - 2, GRID_H - 1);
	endtask

	// The receiver stalls long enough for one result to sit in the output
	// register, a second query to finish behind it and the input to back up.
	task automatic test_output_backpressure();
		hold_left = 4000;
		ask_region(3, 3);
		put_cell(3, 4, 8'h5A);
		put_cell(4, 3, 8'h5A);
		ask_region(3, 4);
		ask_region(10, 10);
		put_cell(10, 11, 8'h00);
		ask_region(10, 11);
	endtask

	// Mostly paints a small block of one value and queries inside it,
	// with single writes of any value and stray queries mixed in.
	task automatic random_burst();
		int c0;
		int r0;
		int w;
		int h;
		int c;
		int r;
		int value;
		int pick;
		pick = $urandom_range(9);
		if (pick <= 5) begin
			c0 = $urandom_range(GRID_W - 1);
			r0 = $urandom_range(GRID_H - 1);
			w = $urandom_range(1, 4);
			h = $urandom_range(1, 4);
			if (c0 + w > GRID_W) w = GRID_W - c0;
			if (r0 + h > GRID_H) h = GRID_H - r0;
			value = pick_value();
			for (r = r0; r < r0 + h; r++) begin
				for (c = c0; c < c0 + w; c++) begin
					put_cell(c, r, value);
				end
			end
			// A broken sequence now and then: painted but never queried.
			if ($urandom_range(7) != 0) begin
				ask_region($urandom_range(c0, c0 + w - 1), $urandom_range(r0, r0 + h - 1));
			end
		end else if (pick <= 7) begin
			put_cell($urandom_range(GRID_W - 1), $urandom_range(GRID_H - 1), pick_value());
		end else begin
			ask_region($urandom_range(GRID_W - 1), $urandom_range(GRID_H - 1));
		end
	endtask

	task automatic test_random_traffic(int items_wanted);
		int phase;
		int goal;
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct = 16;
					sink_idle_pct = 72;
				end
				1: begin
					src_idle_pct = 72;
					sink_idle_pct = 16;
				end
				default: begin
					src_idle_pct = 0;
					sink_idle_pct = 0;
				end
			endcase
			goal = items_sent + items_wanted / 3;
			while (items_sent < goal) begin
				random_burst();
			end
		end
	endtask

	// Result side: random stalls, plus a counted hold-off when one is requested.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		logic [COUNT_W-1:0] expected;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (counts_due.size() == 0) begin
				report_mismatch("count with no query pending", -1, res_ch.chain_count);
			end else begin
				expected = counts_due.pop_front();
				counts_checked++;
				if (res_ch.chain_count !== expected) begin
					report_mismatch("chain_count", expected, res_ch.chain_count);
				end
				if (expected > largest_count) largest_count = expected;
			end
		end
	end

	initial begin
		int waited;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_WRITE;
		req_ch.col = '0;
		req_ch.row = '0;
		req_ch.cell_value = '0;
		res_ch.ready = 1'b0;
		src_idle_pct = 16;
		sink_idle_pct = 72;
		hold_left = 0;
		mismatches = 0;
		items_sent = 0;
		writes_sent = 0;
		queries_sent = 0;
		counts_checked = 0;
		largest_count = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_grid_setup();
		test_directed_regions();
		test_output_backpressure();
		test_random_traffic(300);

		req_ch.valid <= 1'b0;
		while (counts_due.size() != 0) @(posedge clk);
		waited = 0;
		while (waited < FILL_CYCLES) begin
			@(posedge clk);
			waited++;
		end
		if (counts_due.size() != 0) begin
			report_mismatch("queries left without a count", 0, counts_due.size());
		end

		$display("Summary: %0d writes and %0d region queries accepted, %0d counts checked.",
			writes_sent, queries_sent, counts_checked);
		$display("Largest region count seen %0d; stalls on both sides and one long hold-off.",
			largest_count);
		if (mismatches == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Timeout with %0d counts still pending.", counts_due.size());
		$display("tb failed");
		$finish;
	end

endmodule

// ===== grid_flood_fill_region_size.f =====
rtl/core/gff_pkg.sv
rtl/core/gff_if.sv
rtl/core/gff_cell.sv
rtl/core/grid_flood_fill_region_size.sv
rtl/core/gff_checker.sv
test/tb.sv
